FILE: src/cbmt_pkg.sv
// Shared constants, types and helpers for the counter bank with max tracking.
package cbmt_pkg;

    localparam int NUM_COUNTERS = 64;
    localparam int COUNT_BITS   = 16;
    localparam int IDX_W        = $clog2(NUM_COUNTERS);
    localparam int CNT_W        = 7;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(NUM_COUNTERS);

    typedef enum logic [1:0] {
        OP_INC   = 2'd0,
        OP_DEC   = 2'd1,
        OP_CLR   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        logic accept;
        logic modify;
        logic scan_start;
        logic scan_run;
        logic load_direct;
        logic load_held;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_rescan;
        logic scan_done;
    } dp_status_t;

    // out-of-range active count: zero acts as one, above the bank size clamps
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] ac);
        logic [CNT_W-1:0] n;
        if (ac == '0)
            n = CNT_W'(1);
        else if (ac > CNT_W'(NUM_COUNTERS))
            n = CNT_W'(NUM_COUNTERS);
        else
            n = ac;
        return n;
    endfunction

endpackage

FILE: src/cbmt_dp.sv
// Datapath: counter memory, read-modify-write, incremental max tracking and rescan.
module cbmt_dp import cbmt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctl_cmd_t                     cmd,
    output dp_status_t                   st,
    input  logic                         cfg_we,
    input  logic [CNT_W-1:0]             cfg_data,
    input  logic [1:0]                   in_op,
    input  logic [IDX_W-1:0]             in_index,
    output logic signed [COUNT_BITS-1:0] out_value,
    output logic signed [COUNT_BITS-1:0] out_max_value,
    output logic [CNT_W-1:0]             out_max_number,
    output logic                         out_bad_index
);

    logic signed [COUNT_BITS-1:0] mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0]      vld_reg;
    logic signed [COUNT_BITS-1:0] rd_raw_reg;
    logic                         rd_ok_reg;

    op_t                          op_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             ac_reg;
    logic                         dirty_reg;

    logic signed [COUNT_BITS-1:0] max_reg;
    logic [CNT_W-1:0]             holders_reg;
    logic signed [COUNT_BITS-1:0] value_reg;
    logic                         bad_reg;

    logic [CNT_W-1:0]             scan_cnt_reg;
    logic                         scan_vld_reg;
    logic                         first_reg;

    logic signed [COUNT_BITS-1:0] out_value_reg;
    logic signed [COUNT_BITS-1:0] out_max_reg;
    logic [CNT_W-1:0]             out_num_reg;
    logic                         out_bad_reg;

    logic [CNT_W-1:0]             n;
    logic signed [COUNT_BITS-1:0] rd_data;
    logic                         bad;
    logic signed [COUNT_BITS-1:0] new_val;
    logic signed [COUNT_BITS-1:0] res_val;
    logic                         changed;
    logic signed [COUNT_BITS-1:0] max_inc;
    logic [CNT_W-1:0]             hold_inc;
    logic                         drop_last;
    logic                         scan_issue;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         mem_we;

    assign n       = eff_count(ac_reg);
    assign rd_data = rd_ok_reg ? rd_raw_reg : '0;
    assign bad     = {1'b0, idx_reg} >= n;

    always_comb
    begin
        unique case (op_reg)
            OP_INC:   new_val = (rd_data != CNT_MAX) ? rd_data + COUNT_BITS'(1) : rd_data;
            OP_DEC:   new_val = (rd_data != CNT_MIN) ? rd_data - COUNT_BITS'(1) : rd_data;
            OP_CLR:   new_val = '0;
            OP_QUERY: new_val = rd_data;
            default:  new_val = rd_data;
        endcase
    end

    assign res_val = bad ? '0 : new_val;
    assign changed = !bad && (new_val != rd_data);

    // incremental update of max and tie count for a single changed counter
    always_comb
    begin
        max_inc   = max_reg;
        hold_inc  = holders_reg;
        drop_last = 1'b0;
        if (changed)
        begin
            if (new_val > max_reg)
            begin
                max_inc  = new_val;
                hold_inc = CNT_W'(1);
            end
            else if (new_val == max_reg)
            begin
                hold_inc = holders_reg + CNT_W'(1);
            end
            else if (rd_data == max_reg)
            begin
                hold_inc  = holders_reg - CNT_W'(1);
                drop_last = (holders_reg == CNT_W'(1));
            end
        end
    end

    assign st.need_rescan = dirty_reg || drop_last;
    assign st.scan_done   = (scan_cnt_reg == n) && !scan_vld_reg;

    assign scan_issue = cmd.scan_run && (scan_cnt_reg < n);
    assign rd_en      = cmd.accept || scan_issue;
    assign rd_addr    = cmd.accept ? in_index : scan_cnt_reg[IDX_W-1:0];
    assign mem_we     = cmd.modify && !bad && (op_reg != OP_QUERY);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= new_val;
        if (rd_en)
            rd_raw_reg <= mem[rd_addr];
    end

    // valid bits give the all-zero reset without a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[idx_reg] <= 1'b1;
            if (rd_en)
                rd_ok_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_reg       <= ACTIVE_RESET;
            dirty_reg    <= 1'b0;
            max_reg      <= '0;
            holders_reg  <= eff_count(ACTIVE_RESET);
            scan_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ac_reg    <= cfg_data;
                dirty_reg <= 1'b1;
            end
            if (cmd.modify)
            begin
                max_reg     <= max_inc;
                holders_reg <= hold_inc;
            end
            if (cmd.scan_start)
            begin
                dirty_reg    <= 1'b0;
                scan_cnt_reg <= '0;
                scan_vld_reg <= 1'b0;
                first_reg    <= 1'b1;
            end
            else if (cmd.scan_run)
            begin
                scan_vld_reg <= scan_issue;
                if (scan_issue)
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                if (scan_vld_reg)
                begin
                    if (first_reg || rd_data > max_reg)
                    begin
                        max_reg     <= rd_data;
                        holders_reg <= CNT_W'(1);
                        first_reg   <= 1'b0;
                    end
                    else if (rd_data == max_reg)
                    begin
                        holders_reg <= holders_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op_t'(in_op);
            idx_reg <= in_index;
        end
        if (cmd.modify)
        begin
            value_reg <= res_val;
            bad_reg   <= bad;
        end
        if (cmd.load_direct)
        begin
            out_value_reg <= res_val;
            out_max_reg   <= max_inc;
            out_num_reg   <= hold_inc;
            out_bad_reg   <= bad;
        end
        else if (cmd.load_held)
        begin
            out_value_reg <= value_reg;
            out_max_reg   <= max_reg;
            out_num_reg   <= holders_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign out_value      = out_value_reg;
    assign out_max_value  = out_max_reg;
    assign out_max_number = out_num_reg;
    assign out_bad_index  = out_bad_reg;

`ifndef ASSERT_OFF
    a_direct_no_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_direct |-> !st.need_rescan)
        else $error("result loaded directly while a rescan was due");
`endif

endmodule

FILE: src/cbmt_ctrl.sv
// Controller: item sequencing, rescan control and output word valid.
module cbmt_ctrl import cbmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MODIFY = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                if (st.need_rescan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.load_direct = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (st.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_held = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_direct || cmd.load_held)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_direct || cmd.load_held) |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("rescan left to an unexpected state");
`endif

endmodule

FILE: src/counter_bank_with_max_tracking.sv
// Top level: bank of saturating signed counters with max value and tie count.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid / in_stall   | op, index
//  out     | out_valid / out_stall | value, max_value, max_number, bad_index
//  cfg     | cfg_valid / cfg_ready | active_count
//
// An item is accepted with the counter memory read, then updated and written.
// When the sole holder of the max drops, or after an active_count write, a rescan
// reads the n active counters through the single memory read port.
// Reset clears counters through per-entry valid bits; no clearing pass.
// A new item is taken while the previous result word waits on out_stall.
module counter_bank_with_max_tracking import cbmt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [IDX_W-1:0]             index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COUNT_BITS-1:0] value,
    output logic signed [COUNT_BITS-1:0] max_value,
    output logic [CNT_W-1:0]             max_number,
    output logic                         bad_index,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CNT_W-1:0]             active_count
);

    ctl_cmd_t   cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    cbmt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    cbmt_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (active_count),
        .in_op          (op),
        .in_index       (index),
        .out_value      (value),
        .out_max_value  (max_value),
        .out_max_number (max_number),
        .out_bad_index  (bad_index)
    );

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_index) |-> (value == '0))
        else $error("bad index word carries a nonzero value");
    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_index) |-> (max_value >= value))
        else $error("counter value above reported max");
    a_ties_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_number != '0))
        else $error("max holder count is zero");
`endif

endmodule

FILE: sim/cbmt_result_checker.sv
// Result checker for the counter bank: tracks the bank, predicts every result word and compares.
`timescale 1ns / 100ps

module cbmt_result_checker import cbmt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [IDX_W-1:0]             index,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [COUNT_BITS-1:0] value,
    input  logic signed [COUNT_BITS-1:0] max_value,
    input  logic [CNT_W-1:0]             max_number,
    input  logic                         bad_index,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CNT_W-1:0]             active_count,
    output int                           fails,
    output int                           pending
);

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] value;
        logic signed [COUNT_BITS-1:0] max_value;
        logic [CNT_W-1:0]             max_number;
        logic                         bad_index;
    } tally_t;

    logic signed [COUNT_BITS-1:0] bank [NUM_COUNTERS];
    logic [CNT_W-1:0]             size_reg;
    tally_t                       due_tallies[$];

    // apply one op to the shadow bank, then find the max and its holders over the live range
    function automatic tally_t predict_tally(input op_t o, input logic [IDX_W-1:0] idx);
        tally_t                       t;
        int                           live;
        int                           ties;
        logic signed [COUNT_BITS-1:0] c;
        logic signed [COUNT_BITS-1:0] best;
        if (size_reg == '0)
            live = 1;
        else if (size_reg > NUM_COUNTERS)
            live = NUM_COUNTERS;
        else
            live = int'(size_reg);
        t = '0;
        if (int'(idx) >= live)
            t.bad_index = 1'b1;
        else
        begin
            c = bank[idx];
            case (o)
                OP_INC: if (c != CNT_MAX) c = c + COUNT_BITS'(1);
                OP_DEC: if (c != CNT_MIN) c = c - COUNT_BITS'(1);
                OP_CLR: c = '0;
                default: ;
            endcase
            bank[idx] = c;
            t.value = c;
        end
        best = bank[0];
        ties = 0;
        for (int k = 0; k < live; k++)
        begin
            if (bank[k] > best)
            begin
                best = bank[k];
                ties = 1;
            end
            else if (bank[k] == best)
                ties++;
        end
        t.max_value  = best;
        t.max_number = CNT_W'(ties);
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        tally_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COUNTERS; k++)
                bank[k] = '0;
            size_reg = ACTIVE_RESET;
            due_tallies.delete();
            fails = 0;
        end
        else
        begin
            // result side first: a word leaving now was caused by an earlier input
            if (out_valid && !out_stall)
            begin
                got = '{value, max_value, max_number, bad_index};
                if (due_tallies.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $write("%0t: result word with none expected: value %0d max %0d",
                               $realtime, got.value, got.max_value);
                        $display(" ties %0d bad %0b", got.max_number, got.bad_index);
                    end
                    fails++;
                end
                else
                begin
                    want = due_tallies.pop_front();
                    if (got.value !== want.value || got.max_value !== want.max_value ||
                        got.max_number !== want.max_number || got.bad_index !== want.bad_index)
                    begin
                        if (fails < 10)
                        begin
                            $write("%0t: mismatch: expected value %0d max %0d ties %0d bad %0b,",
                                   $realtime, want.value, want.max_value, want.max_number,
                                   want.bad_index);
                            $display(" got value %0d max %0d ties %0d bad %0b",
                                     got.value, got.max_value, got.max_number, got.bad_index);
                        end
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                size_reg = active_count;
            if (in_valid && !in_stall)
                due_tallies.insert(due_tallies.size(), predict_tally(op_t'(op), index));
        end
        pending = due_tallies.size();
    end

endmodule

FILE: sim/counter_bank_with_max_tracking_tb.sv
// Testbench top: drives the counter bank with directed, back-to-back and random words.
`timescale 1ns / 100ps

module counter_bank_with_max_tracking_tb;
    import cbmt_pkg::*;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   op;
    logic [IDX_W-1:0]             index;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [COUNT_BITS-1:0] value;
    logic signed [COUNT_BITS-1:0] max_value;
    logic [CNT_W-1:0]             max_number;
    logic                         bad_index;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CNT_W-1:0]             active_count;
    int                           fails;
    int                           pending;
    int                           gap_pct;
    int                           stall_pct;

    counter_bank_with_max_tracking DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .index        (index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .max_value    (max_value),
        .max_number   (max_number),
        .bad_index    (bad_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .active_count (active_count)
    );

    cbmt_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .index        (index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .max_value    (max_value),
        .max_number   (max_number),
        .bad_index    (bad_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .active_count (active_count),
        .fails        (fails),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        int n;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(10, 40);
        else
            n = $urandom_range(1, 3);
        return n;
    endfunction

    // called at a falling edge; returns at a falling edge with in_valid possibly still high
    task automatic send_word(input op_t o, input logic [IDX_W-1:0] idx);
        in_valid <= 1'b1;
        op       <= o;
        index    <= idx;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat (pause_len()) @(negedge clk);
        end
    endtask

    // only once the bank has drained
    task automatic write_active(input logic [CNT_W-1:0] n);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_valid    <= 1'b1;
        active_count <= n;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat (pause_len() - 1) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int   sizes [8];
        int   live;
        int   r;
        op_t  o;
        logic [IDX_W-1:0] idx;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_INC;
        index        = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        active_count = ACTIVE_RESET;
        gap_pct      = 30;
        stall_pct    = 30;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: every op, bank edges, bad indexes, shrink and regrow
        write_active(7'd64);
        send_word(OP_QUERY, 6'd0);
        send_word(OP_INC, 6'd0);
        send_word(OP_INC, 6'd63);
        send_word(OP_DEC, 6'd0);
        send_word(OP_DEC, 6'd63);       // last max holder drops
        send_word(OP_DEC, 6'd5);
        send_word(OP_CLR, 6'd5);
        send_word(OP_INC, 6'd42);
        send_word(OP_CLR, 6'd42);
        send_word(OP_INC, 6'd50);
        send_word(OP_INC, 6'd50);
        write_active(7'd10);            // counter 50 drops out of the max
        send_word(OP_QUERY, 6'd3);
        send_word(OP_INC, 6'd10);       // just past the live range
        write_active(7'd64);
        send_word(OP_QUERY, 6'd50);
        write_active(7'd0);             // acts as one counter
        send_word(OP_INC, 6'd0);
        send_word(OP_DEC, 6'd1);
        send_word(OP_CLR, 6'd63);
        write_active(7'd127);           // clamps to the full bank
        send_word(OP_INC, 6'd63);
        send_word(OP_QUERY, 6'd50);

        // up and down on a single live counter, no idling
        gap_pct   = 0;
        stall_pct = 0;
        write_active(7'd1);
        send_word(OP_CLR, 6'd0);
        repeat (10) send_word(OP_INC, 6'd0);
        send_word(OP_QUERY, 6'd0);
        repeat (12) send_word(OP_DEC, 6'd0);
        send_word(OP_INC, 6'd0);
        send_word(OP_CLR, 6'd0);

        // random phases over several bank sizes, extremes included
        sizes = '{64, 1, 0, 127, 2, 65, 37, 0};
        sizes[7] = $urandom_range(0, 127);
        for (int ph = 0; ph < 8; ph++)
        begin
            gap_pct   = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 20 : 50;
            stall_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 25 : 50;
            write_active(CNT_W'(sizes[ph]));
            live = (sizes[ph] == 0) ? 1 : (sizes[ph] > NUM_COUNTERS) ? NUM_COUNTERS : sizes[ph];
            repeat (125)
            begin
                r = $urandom_range(0, 9);
                o = (r < 4) ? OP_INC : (r < 7) ? OP_DEC : (r < 8) ? OP_CLR : OP_QUERY;
                if ($urandom_range(0, 99) < 85)
                    idx = IDX_W'($urandom_range(0, live - 1));
                else
                    idx = IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
                send_word(o, idx);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
